[src/deq_pkg.sv]
// Shared codes and types for the double-ended queue.
// Holds request codes, status codes, field widths and the control state enum.
package deq_pkg;

  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 6;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_ALL   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } deq_state_t;

endpackage

[src/deq_ram.sv]
// Element store of the double-ended queue: one write port, one read port.
// Read data is registered and holds until the next read. No package needed.
module deq_ram #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/double_ended_queue.sv]
// Bounded double-ended queue of DATA_WIDTH-bit words in a circular store of DEPTH
// entries. One request is in flight at a time. Pushes, failed pops, read-alls of an
// empty queue and unknown request codes load their result word at the edge that
// accepts them, so the word shows in the next cycle; they run one per cycle
// while the output is not stalled. A pop reads its value through the store's
// single registered read port and loads it into the result word from S_POP,
// waiting there while the output is stalled. A read-all starts its first read on
// acceptance, then sends one word per cycle while the output is not stalled. Popped
// and read-out values are zero-extended to 32 bits. Depends on deq_pkg and deq_ram.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [REQ_W-1:0]           req_type,
  input  logic signed [VALUE_W-1:0]  push_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic [STATUS_W-1:0]        status,
  output logic                       last,
  output logic [OCC_W-1:0]           occupancy
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  deq_state_t state, state_next;

  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  out_load;
  logic [VALUE_W-1:0]    value_next;
  logic [STATUS_W-1:0]   status_next;
  logic                  last_next;
  logic [OCC_W-1:0]      occ_next;

  logic out_free, accept, full, empty;
  logic [AW-1:0] front_inc, front_dec, ptr_inc, back_addr, tail_addr;
  logic [EXT_W-1:0] push_ext, rd_ext;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign ptr_inc   = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
  assign back_addr = wrap_add(front, count - CW'(1));
  assign tail_addr = wrap_add(front, count);

  assign push_ext  = EXT_W'($unsigned(push_value));
  assign mem_wdata = push_ext[DATA_WIDTH-1:0];
  assign rd_ext    = EXT_W'(mem_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    rd_ptr <= rd_ptr_next;
  end

  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    idx_next    = idx;
    rd_ptr_next = rd_ptr;
    mem_we      = 1'b0;
    mem_waddr   = tail_addr;
    mem_re      = 1'b0;
    mem_raddr   = front;
    out_load    = 1'b0;
    value_next  = '0;
    status_next = ST_OK;
    last_next   = 1'b1;
    occ_next    = OCC_W'(count);

    case (state)
      S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
                occ_next   = OCC_W'(count + CW'(1));
                if (req_type == REQ_PUSH_FRONT) begin
                  mem_waddr  = front_dec;
                  front_next = front_dec;
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                // hold the result until the read data comes back
                out_load   = 1'b0;
                mem_re     = 1'b1;
                count_next = count - CW'(1);
                state_next = S_POP;
                if (req_type == REQ_POP_FRONT) begin
                  front_next = front_inc;
                end else begin
                  mem_raddr = back_addr;
                end
              end
            end
            REQ_READ_ALL: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                out_load    = 1'b0;
                mem_re      = 1'b1;
                rd_ptr_next = front_inc;
                idx_next    = '0;
                state_next  = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load   = 1'b1;
          value_next = rd_ext[VALUE_W-1:0];
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load   = 1'b1;
          value_next = rd_ext[VALUE_W-1:0];
          last_next  = (idx + CW'(1) == count);
          if (last_next) begin
            state_next = S_IDLE;
          end else begin
            // fetch the next word while this one goes out
            mem_re      = 1'b1;
            mem_raddr   = rd_ptr;
            rd_ptr_next = ptr_inc;
            idx_next    = idx + CW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= $signed(value_next);
      status    <= status_next;
      last      <= last_next;
      occupancy <= occ_next;
    end
  end

endmodule

[src/deq_checker.sv]
// Port-level checks for the double-ended queue, bound to its top level.
// Depends on deq_pkg for request and status codes.
module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [REQ_W-1:0]          req_type,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [VALUE_W-1:0] out_value,
  input logic [STATUS_W-1:0]       status,
  input logic                      last,
  input logic [OCC_W-1:0]          occupancy
);

  // a blocked result must keep new requests out
  a_blocked_out_stalls_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request accepted while result word is blocked");

  // pushes answer in the next cycle with a single final word
  a_push_answers: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
    (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK)
    |=> out_valid && last && out_value == '0)
    else $error("push result missing or malformed");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> occupancy == '0 && out_value == '0 && last)
    else $error("underflow word malformed");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> occupancy == OCC_W'(DEPTH) && last)
    else $error("overflow word with queue not full");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(status) &&
    $stable(last) && $stable(occupancy))
    else $error("stalled result word changed");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_value (out_value),
  .status    (status),
  .last      (last),
  .occupancy (occupancy)
);

[tb/double_ended_queue_tb.sv]
// Self-checking testbench for double_ended_queue: random pushes, pops and read-outs
// with random idling on both sides, checked word by word against a mirror of the deque.
// Depends on deq_pkg and the double_ended_queue RTL.
module double_ended_queue_tb;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int RANDOM_REQS = 380;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 80;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [VALUE_W-1:0] value;
    bit                 wait_idle;
  } request_t;

  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic [OCC_W-1:0]    occ;
  } result_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [REQ_W-1:0]           req_type = '0;
  logic signed [VALUE_W-1:0]  push_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [VALUE_W-1:0]  out_value;
  logic [STATUS_W-1:0]        status;
  logic                       last;
  logic [OCC_W-1:0]           occupancy;

  request_t     pending_requests[$];
  result_word_t due_words[$];

  logic [VALUE_W-1:0] mirror_store [0:DEPTH-1];
  logic [IDX_W-1:0]   mirror_front;
  int                 mirror_count;

  int       error_count = 0;
  int       gap_left = 0;
  bit       sender_burst = 1'b0;
  bit       recv_burst = 1'b0;
  int       stall_left = 0;
  int       recv_cycle = 0;
  int       recv_roll;
  bit       accepted_now;
  request_t next_req;

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .status     (status),
    .last       (last),
    .occupancy  (occupancy)
  );

  always #4 clk = ~clk;

  task automatic due_word(input logic [VALUE_W-1:0] v, input logic [STATUS_W-1:0] s,
                          input logic l);
    result_word_t w;
    w.value  = v;
    w.status = s;
    w.last   = l;
    w.occ    = mirror_count[OCC_W-1:0];
    due_words.push_back(w);
  endtask

  // Advance the mirror by one request and queue the words it must produce.
  task automatic deque_apply(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] got;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          due_word('0, ST_FULL, 1'b1);
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            mirror_front = mirror_front - 1'b1;
            idx = mirror_front;
          end else begin
            idx = mirror_front + IDX_W'(mirror_count);
          end
          mirror_store[idx] = val;
          mirror_count++;
          due_word('0, ST_OK, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (mirror_count == 0) begin
          due_word('0, ST_EMPTY, 1'b1);
        end else begin
          if (req == REQ_POP_FRONT) begin
            got = mirror_store[mirror_front];
            mirror_front = mirror_front + 1'b1;
          end else begin
            got = mirror_store[mirror_front + IDX_W'(mirror_count - 1)];
          end
          mirror_count--;
          due_word(got, ST_OK, 1'b1);
        end
      end
      REQ_READ_ALL: begin
        if (mirror_count == 0) begin
          due_word('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < mirror_count; i++) begin
            due_word(mirror_store[mirror_front + IDX_W'(i)], ST_OK, i == mirror_count - 1);
          end
        end
      end
      default: due_word('0, ST_OK, 1'b1);
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
    if (sender_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h8000_0000;
    if (r < 16) return 32'h7FFF_FFFF;
    if (r < 21) return '0;
    if (r < 26) return '1;
    return $urandom;
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val);
    request_t q;
    q.req       = req;
    q.value     = val;
    q.wait_idle = 1'b0;
    pending_requests.push_back(q);
  endtask

  task automatic queue_idle_wait();
    request_t q;
    q.req       = REQ_PUSH_FRONT;
    q.value     = '0;
    q.wait_idle = 1'b1;
    pending_requests.push_back(q);
  endtask

  // Sender: hold a stalled word, otherwise idle or present the next request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      accepted_now = in_valid;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_requests[0].wait_idle) begin
        in_valid <= 1'b0;
        if (!accepted_now && !out_valid && due_words.size() == 0)
          void'(pending_requests.pop_front());
      end else begin
        next_req = pending_requests.pop_front();
        in_valid   <= 1'b1;
        req_type   <= next_req.req;
        push_value <= next_req.value;
        gap_left   <= pick_gap();
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the deque up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      recv_cycle = 0;
    end else begin
      recv_cycle++;
      if (recv_cycle == HOLD_AT) stall_left = HOLD_LEN;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
        recv_roll = $urandom_range(0, 99);
        if (recv_burst || recv_roll < 65) begin
          out_stall <= 1'b0;
        end else if (recv_roll < 95) begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(6, 24);
        end
      end
    end
  end

  // Monitor: predict on accepted requests, then check the word taken at the output.
  always @(posedge clk) begin
    result_word_t w;
    if (rst) begin
      mirror_front = '0;
      mirror_count = 0;
    end else begin
      if (in_valid && !in_stall) deque_apply(req_type, push_value);
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("result word with nothing expected: out_value %0d status %0d",
                 out_value, status);
          error_count++;
        end else begin
          w = due_words.pop_front();
          if (out_value !== w.value) begin
            $error("out_value: expected %0d, got %0d", $signed(w.value), out_value);
            error_count++;
          end
          if (status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status);
            error_count++;
          end
          if (last !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, last);
            error_count++;
          end
          if (occupancy !== w.occ) begin
            $error("occupancy: expected %0d, got %0d", w.occ, occupancy);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int made;
    int phase_len;
    int push_pct;
    int r;
    bit mid_wait_done;

    // Empty corner cases, push and pop back of one element, then mixed requests to empty.
    queue_req(REQ_READ_ALL, $urandom);
    queue_req(REQ_POP_FRONT, $urandom);
    queue_req(REQ_POP_BACK, $urandom);
    queue_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    queue_req(REQ_POP_BACK, $urandom);
    queue_req(REQ_PUSH_FRONT, 32'h8000_0000);
    queue_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    queue_req(REQ_PUSH_FRONT, 32'h0000_0000);
    queue_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    queue_req(REQ_READ_ALL, $urandom);
    queue_req(3'd5, $urandom);
    queue_req(3'd6, $urandom);
    queue_req(3'd7, $urandom);
    queue_req(REQ_POP_FRONT, $urandom);
    queue_req(REQ_POP_BACK, $urandom);
    queue_req(REQ_READ_ALL, $urandom);
    queue_req(REQ_POP_FRONT, $urandom);
    queue_req(REQ_POP_FRONT, $urandom);
    queue_req(REQ_POP_BACK, $urandom);
    queue_req(REQ_PUSH_FRONT, 32'h5A5A_A5A5);
    queue_req(REQ_POP_FRONT, $urandom);
    queue_idle_wait();

    // Random phases biased toward filling or draining so both full and empty recur.
    made = 0;
    mid_wait_done = 1'b0;
    while (made < RANDOM_REQS) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 88;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int k = 0; k < phase_len && made < RANDOM_REQS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2)
          queue_req(REQ_W'($urandom_range(5, 7)), pick_value());
        else if (r < 9)
          queue_req(REQ_READ_ALL, pick_value());
        else if ($urandom_range(0, 99) < push_pct)
          queue_req($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
        else
          queue_req($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT, pick_value());
        made++;
        if (!mid_wait_done && made >= RANDOM_REQS / 2) begin
          queue_idle_wait();
          mid_wait_done = 1'b1;
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (due_words.size() != 0) begin
      $error("%0d expected result words never arrived", due_words.size());
      error_count++;
    end
    if (error_count == 0)
      $display("double_ended_queue_tb passed");
    else
      $display("double_ended_queue_tb failed");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("double_ended_queue_tb failed");
    $finish;
  end

endmodule
